/* src/rsd_pkg.sv */
// Shared types and constants for the running standard deviation block.
package rsd_pkg;

	localparam int SAMPLE_PORT_W = 24;
	localparam int STD_W         = 32;
	localparam int COUNT_OUT_W   = 13;
	localparam int M2_W          = 64;
	localparam int ITER_W        = 7;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD,
		ST_MUL,
		ST_ACC,
		ST_VLOAD,
		ST_VDIV,
		ST_SQLOAD,
		ST_SQRT,
		ST_OUT
	} rsd_state_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic upd;
		logic mul_step;
		logic acc;
		logic vload;
		logic sq_load;
		logic sq_step;
		logic out_load;
	} rsd_cmd_t;

	typedef struct packed {
		logic full;
		logic last;
		logic out_free;
	} rsd_stat_t;

endpackage

/* src/running_standard_deviation.sv */
// Running population standard deviation, Welford update with iterative units.
// Each sample is accepted, divided by the new count for the mean step, added to the mean,
// multiplied and accumulated; the one-bit-per-cycle divider and two-bit multiplier iterate.
// A last sample then adds a variance divide by the count and a square root.
// One sample at a time; the result waits in an output register.
// Asynchronous active-low reset clears count, mean, deviation sum and flags.
module running_standard_deviation #(
	parameter int SAMPLE_BITS   = 24,
	parameter int MAX_SAMPLES   = 4096,
	parameter int FRACTION_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rsd_pkg::SAMPLE_PORT_W-1:0]   sample,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rsd_pkg::STD_W-1:0]           std_dev,
	output logic [rsd_pkg::COUNT_OUT_W-1:0]     sample_count,
	output logic                                overflow
);
	import rsd_pkg::*;

	localparam int SUSE = (SAMPLE_BITS < SAMPLE_PORT_W) ? SAMPLE_BITS : SAMPLE_PORT_W;
	localparam int XW   = SUSE + FRACTION_BITS;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int PW   = (2 * XW > M2_W) ? 2 * XW : M2_W + 1;
	localparam int MS   = (XW + 1) / 2;

	rsd_cmd_t  cmd;
	rsd_stat_t stat;

	rsd_ctrl #(
		.XW(XW),
		.MS(MS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (last),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rsd_dp #(
		.SUSE        (SUSE),
		.FB          (FRACTION_BITS),
		.XW          (XW),
		.CW          (CW),
		.PW          (PW),
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.sample       (sample),
		.last         (last),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.std_dev      (std_dev),
		.sample_count (sample_count),
		.overflow     (overflow)
	);

`ifndef SYNTH
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("output register overwritten");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !stat.full) |=> !in_ready)
		else $error("new transfer taken during update");

	a_out_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("result not presented");
`endif

endmodule

/* src/rsd_ctrl.sv */
// Controller state machine sequencing the update, divide, multiply and root steps.
module rsd_ctrl #(
	parameter int XW = 32,
	parameter int MS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  rsd_pkg::rsd_stat_t stat,
	output rsd_pkg::rsd_cmd_t  cmd
);
	import rsd_pkg::*;

	rsd_state_t        state_q, state_d;
	logic [ITER_W-1:0] iter_q, iter_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		iter_d   = iter_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.full) begin
						state_d = in_last ? ST_VLOAD : ST_IDLE;
					end else begin
						state_d = ST_DIV;
						iter_d  = ITER_W'(XW - 1);
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (iter_q == '0) state_d = ST_UPD;
				else iter_d = iter_q - 1'b1;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_MUL;
				iter_d  = ITER_W'(MS - 1);
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (iter_q == '0) state_d = ST_ACC;
				else iter_d = iter_q - 1'b1;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.last ? ST_VLOAD : ST_IDLE;
			end
			ST_VLOAD: begin
				cmd.vload = 1'b1;
				state_d   = ST_VDIV;
				iter_d    = ITER_W'(M2_W - 1);
			end
			ST_VDIV: begin
				cmd.div_step = 1'b1;
				if (iter_q == '0) state_d = ST_SQLOAD;
				else iter_d = iter_q - 1'b1;
			end
			ST_SQLOAD: begin
				cmd.sq_load = 1'b1;
				state_d     = ST_SQRT;
				iter_d      = ITER_W'(STD_W - 1);
			end
			ST_SQRT: begin
				cmd.sq_step = 1'b1;
				if (iter_q == '0) state_d = ST_OUT;
				else iter_d = iter_q - 1'b1;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* src/rsd_dp.sv */
// Datapath: running state, shared radix-2 divider, radix-4 multiplier, square root.
module rsd_dp #(
	parameter int SUSE        = 24,
	parameter int FB          = 8,
	parameter int XW          = 32,
	parameter int CW          = 13,
	parameter int PW          = 65,
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rsd_pkg::rsd_cmd_t                     cmd,
	output rsd_pkg::rsd_stat_t                    stat,
	input  logic [rsd_pkg::SAMPLE_PORT_W-1:0]     sample,
	input  logic                                  last,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [rsd_pkg::STD_W-1:0]             std_dev,
	output logic [rsd_pkg::COUNT_OUT_W-1:0]       sample_count,
	output logic                                  overflow
);
	import rsd_pkg::*;

	// running state
	logic [CW-1:0]   count_q;
	logic [XW-1:0]   mean_q;
	logic [M2_W-1:0] m2_q;
	logic            dropped_q;
	logic            last_q;
	logic            neg_q;
	logic [XW-1:0]   mag_q;

	// divider
	logic [M2_W-1:0] dq_q;
	logic [CW-1:0]   rem_q;
	logic [CW-1:0]   divisor_q;

	// multiplier
	logic [PW-1:0]   mcand_q;
	logic [XW-1:0]   mplier_q;
	logic [PW-1:0]   prod_q;

	// square root
	logic [M2_W-1:0]  sq_v_q;
	logic [STD_W+2:0] sq_rem_q;
	logic [STD_W-1:0] root_q;

	logic            out_valid_q;
	logic            full;
	logic [XW-1:0]   x;
	logic            x_neg;
	logic [XW-1:0]   x_mag;
	logic [CW:0]     r2;
	logic [CW:0]     r2_diff;
	logic            r2_ge;
	logic [XW-1:0]   quot;
	logic [PW-1:0]   pp0, pp1;
	logic [M2_W-1:0] prod_sat;
	logic [M2_W:0]   m2_sum;
	logic [STD_W+2:0] sq_r2, sq_trial;
	logic             sq_ge;

	assign full  = count_q == CW'(MAX_SAMPLES);
	assign x     = XW'(sample[SUSE-1:0]) << FB;
	assign x_neg = x < mean_q;
	assign x_mag = x_neg ? mean_q - x : x - mean_q;

	assign r2      = {rem_q, dq_q[M2_W-1]};
	assign r2_diff = r2 - {1'b0, divisor_q};
	assign r2_ge   = r2 >= {1'b0, divisor_q};
	assign quot    = dq_q[XW-1:0];

	assign pp0      = mplier_q[0] ? mcand_q : '0;
	assign pp1      = mplier_q[1] ? {mcand_q[PW-2:0], 1'b0} : '0;
	assign prod_sat = (|prod_q[PW-1:M2_W]) ? '1 : prod_q[M2_W-1:0];
	assign m2_sum   = {1'b0, m2_q} + {1'b0, prod_sat};

	assign sq_r2    = {sq_rem_q[STD_W:0], sq_v_q[M2_W-1 -: 2]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = sq_r2 >= sq_trial;

	assign stat.full     = full;
	assign stat.last     = last_q;
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;

	// running state and output flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			mean_q      <= '0;
			m2_q        <= '0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				count_q     <= '0;
				mean_q      <= '0;
				m2_q        <= '0;
				dropped_q   <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (out_ready) out_valid_q <= 1'b0;
				if (cmd.accept) begin
					if (full) dropped_q <= 1'b1;
					else count_q <= count_q + 1'b1;
				end
				if (cmd.upd) begin
					if (neg_q) mean_q <= mean_q - quot;
					else mean_q <= mean_q + quot;
				end
				if (cmd.acc) m2_q <= m2_sum[M2_W] ? '1 : m2_sum[M2_W-1:0];
			end
		end
	end

	// payload and arithmetic units
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			last_q    <= last;
			neg_q     <= x_neg;
			mag_q     <= x_mag;
			dq_q      <= M2_W'(x_mag) << (M2_W - XW);
			rem_q     <= '0;
			divisor_q <= count_q + 1'b1;
		end
		if (cmd.vload) begin
			dq_q      <= m2_q;
			rem_q     <= '0;
			divisor_q <= count_q;
		end
		if (cmd.div_step) begin
			rem_q <= r2_ge ? r2_diff[CW-1:0] : r2[CW-1:0];
			dq_q  <= {dq_q[M2_W-2:0], r2_ge};
		end
		if (cmd.upd) begin
			mcand_q  <= PW'(mag_q);
			mplier_q <= mag_q - quot;
			prod_q   <= '0;
		end
		if (cmd.mul_step) begin
			prod_q   <= prod_q + pp0 + pp1;
			mcand_q  <= mcand_q << 2;
			mplier_q <= mplier_q >> 2;
		end
		if (cmd.sq_load) begin
			sq_v_q   <= dq_q;
			sq_rem_q <= '0;
			root_q   <= '0;
		end
		if (cmd.sq_step) begin
			sq_v_q   <= sq_v_q << 2;
			sq_rem_q <= sq_ge ? sq_r2 - sq_trial : sq_r2;
			root_q   <= {root_q[STD_W-2:0], sq_ge};
		end
		if (cmd.out_load) begin
			std_dev      <= root_q;
			sample_count <= COUNT_OUT_W'(count_q);
			overflow     <= dropped_q;
		end
	end

endmodule
